@@ rtl/core/ithf_pkg.sv @@
// Shared types, constants and helpers for the IPv4 transmit header fragmenter.
package ithf_pkg;

    // Header field constants
    localparam logic [7:0]  HDR_VER_IHL   = 8'h45;
    localparam logic [7:0]  HDR_TOS       = 8'h00;
    localparam logic [15:0] HDR_BYTES     = 16'd20;
    localparam logic [7:0]  TTL_DEFAULT   = 8'd64;

    // Fragment size limits
    localparam int          FRAG_W        = 11;
    localparam logic [10:0] FRAG_FLOOR    = 11'd1024;
    localparam logic [10:0] FRAG_CEIL     = 11'd1480;

    // Configuration port
    localparam int          CFG_IDX_W     = 8;
    localparam int          CFG_DATA_W    = 32;
    localparam logic [7:0]  CFG_SRC_ADDR  = 8'd0;
    localparam logic [7:0]  CFG_FRAG_MAX  = 8'd1;

    // Number of fixed header words folded into the per-datagram base sum
    localparam int          BASE_WORDS    = 7;
    localparam int          BASE_CNT_W    = $clog2(BASE_WORDS);

    typedef struct packed {
        logic [15:0] payload_length;
        logic [31:0] destination_address;
        logic [7:0]  protocol_number;
    } t_in_item;

    typedef struct packed {
        logic [63:0] header_bytes_0_7;
        logic [63:0] header_bytes_8_15;
        logic [31:0] header_bytes_16_19;
        logic [15:0] slice_start;
        logic [10:0] slice_length;
        logic        last_fragment;
    } t_out_item;

    // Command to the shared one's-complement adder
    typedef struct packed {
        logic        en;
        logic        restart;
        logic [15:0] init;
        logic [15:0] word;
    } t_ocu_cmd;

    // Datagram context handed from the top to the sequencer
    typedef struct packed {
        logic [31:0] source_address;
        logic [10:0] frag_max;
        logic [15:0] id;
    } t_ctx;

    // Effective fragment size: clamp to range, clear the low three bits
    function automatic logic [10:0] eff_frag_max(input logic [10:0] raw);
        logic [10:0] v;
        v = raw;
        if (v < FRAG_FLOOR) v = FRAG_FLOOR;
        if (v > FRAG_CEIL)  v = FRAG_CEIL;
        return {v[10:3], 3'b000};
    endfunction

endpackage

@@ rtl/core/ithf_ocadd.sv @@
// Shared 16-bit one's-complement accumulator with end-around carry.
module ithf_ocadd
    import ithf_pkg::*;
(
    input  logic     i_clk,
    input  t_ocu_cmd i_cmd,
    output logic [15:0] o_acc
);

    logic [15:0] r_acc;
    logic [15:0] n_acc;
    logic [15:0] base;
    logic [16:0] sum;

    // One add per cycle, carry folded back in
    always_comb begin
        base  = i_cmd.restart ? i_cmd.init : r_acc;
        sum   = {1'b0, base} + {1'b0, i_cmd.word};
        n_acc = sum[15:0] + {15'd0, sum[16]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/core/ithf_ctrl.sv @@
// Fragment sequencer: drives the shared adder and loads the output register.
module ithf_ctrl
    import ithf_pkg::*;
#(
    parameter logic [7:0] TIME_TO_LIVE = TTL_DEFAULT
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    input  t_ctx        i_ctx,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    output t_ocu_cmd    o_cmd,
    input  logic [15:0] i_acc
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BASE  = 6'b000010,
        S_SAVE  = 6'b000100,
        S_FRAG  = 6'b001000,
        S_FLAGS = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [BASE_CNT_W-1:0] r_cnt, n_cnt;
    t_in_item        r_req;
    logic [15:0]     r_id;
    logic [15:0]     r_base;
    logic [15:0]     r_pos;
    logic [10:0]     r_len;
    logic            r_last;
    logic [15:0]     r_total;
    logic [15:0]     r_flags;
    logic            r_out_valid;
    t_out_item       r_out;

    logic [10:0]     fmax;
    logic [15:0]     rem;
    logic            frag_last;
    logic [10:0]     frag_len;
    logic [15:0]     base_word;
    logic            out_free;

    assign fmax      = eff_frag_max(i_ctx.frag_max);
    assign rem       = r_req.payload_length - r_pos;
    assign frag_last = (rem <= {5'd0, fmax});
    assign frag_len  = frag_last ? rem[10:0] : fmax;
    assign out_free  = !r_out_valid || i_out_ready;

    // Fixed header words, one per base step
    always_comb begin
        case (r_cnt)
            3'd0:    base_word = {HDR_VER_IHL, HDR_TOS};
            3'd1:    base_word = r_id;
            3'd2:    base_word = {TIME_TO_LIVE, r_req.protocol_number};
            3'd3:    base_word = i_ctx.source_address[31:16];
            3'd4:    base_word = i_ctx.source_address[15:0];
            3'd5:    base_word = r_req.destination_address[31:16];
            3'd6:    base_word = r_req.destination_address[15:0];
            default: base_word = 16'd0;
        endcase
    end

    // Next state and adder command
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) n_state = S_BASE;
            end
            S_BASE: begin
                o_cmd.en      = 1'b1;
                o_cmd.restart = (r_cnt == '0);
                o_cmd.init    = 16'd0;
                o_cmd.word    = base_word;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == BASE_CNT_W'(BASE_WORDS - 1)) n_state = S_SAVE;
            end
            S_SAVE: begin
                n_state = S_FRAG;
            end
            S_FRAG: begin
                o_cmd.en      = 1'b1;
                o_cmd.restart = 1'b1;
                o_cmd.init    = r_base;
                o_cmd.word    = {5'd0, frag_len} + HDR_BYTES;
                n_state       = S_FLAGS;
            end
            S_FLAGS: begin
                o_cmd.en   = 1'b1;
                o_cmd.word = r_flags;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = r_last ? S_IDLE : S_FRAG;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datagram and fragment payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_item;
            r_id  <= i_ctx.id;
            r_pos <= 16'd0;
        end
        if (r_state == S_SAVE) begin
            r_base <= i_acc;
        end
        if (r_state == S_FRAG) begin
            r_len   <= frag_len;
            r_last  <= frag_last;
            r_total <= {5'd0, frag_len} + HDR_BYTES;
            r_flags <= {2'b00, !frag_last, r_pos[15:3]};
        end
        if (r_state == S_EMIT && out_free) begin
            r_out.header_bytes_0_7   <= {HDR_VER_IHL, HDR_TOS, r_total, r_id, r_flags};
            r_out.header_bytes_8_15  <= {TIME_TO_LIVE, r_req.protocol_number, ~i_acc,
                                         i_ctx.source_address};
            r_out.header_bytes_16_19 <= r_req.destination_address;
            r_out.slice_start        <= r_pos;
            r_out.slice_length       <= r_len;
            r_out.last_fragment      <= r_last;
            r_pos                    <= r_pos + {5'd0, r_len};
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ rtl/core/ipv4_tx_header_fragmenter_top.sv @@
// Top level of the IPv4 transmit header fragmenter.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one datagram
//   request: payload length, destination and protocol. Each request draws
//   the next 16-bit identification from a wrapping counter.
//   Output channel (o_out_valid / i_out_ready / o_out_item) gives one item
//   per fragment, in order of offset, with the full 20-byte header, the
//   payload slice and a last marker.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the
//   source address (index 0) and the fragment payload limit (index 1);
//   write only while the block is idle.
// Sequence:
//   A request first runs the base checksum work (seven header words on
//   the shared one's-complement adder, then a save step), then for each
//   fragment a length add, a flags add and a load. Input ready stays low
//   from acceptance until the last fragment is loaded, so a new request
//   waits for the previous one. The single shared adder orders these steps.
//   A stalled receiver holds the output register; the sequencer waits in
//   its load step until the register frees.
// Reset: synchronous, active low; clears sequencer, output valid, ID counter, config.
module ipv4_tx_header_fragmenter_top
    import ithf_pkg::*;
#(
    parameter logic [7:0] TIME_TO_LIVE = TTL_DEFAULT
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [31:0] r_src_addr;
    logic [10:0] r_frag_max;
    logic [15:0] r_id;
    t_ctx        ctx;
    t_ocu_cmd    cmd;
    logic [15:0] acc;

    // Configuration registers and identification counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= 32'd0;
            r_frag_max <= FRAG_CEIL;
            r_id       <= 16'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SRC_ADDR: r_src_addr <= i_cfg_data;
                    CFG_FRAG_MAX: r_frag_max <= i_cfg_data[FRAG_W-1:0];
                    default:      ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                r_id <= r_id + 16'd1;
            end
        end
    end

    assign o_cfg_ready        = 1'b1;
    assign ctx.source_address = r_src_addr;
    assign ctx.frag_max       = r_frag_max;
    assign ctx.id             = r_id;

    ithf_ctrl #(
        .TIME_TO_LIVE (TIME_TO_LIVE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_ctx       (ctx),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_cmd       (cmd),
        .i_acc       (acc)
    );

    ithf_ocadd u_ocadd (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .o_acc  (acc)
    );

`ifndef SYNTHESIS
    // An accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready high right after a request was accepted");

    // Total length field matches the slice length plus the header
    a_length_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.header_bytes_0_7[47:32] ==
                         ({5'd0, o_out_item.slice_length} + HDR_BYTES)))
        else $error("total length does not match slice length");

    // MF flag is set exactly on the fragments that are not last
    a_mf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.header_bytes_0_7[13] == !o_out_item.last_fragment))
        else $error("MF flag disagrees with last fragment marker");
`endif

endmodule
